// File: src/frmavg_pkg.sv
`timescale 1ns / 1ps
// Package for the frame rate moving average unit.
// Holds field widths, fixed-point constants and the control state type.
// No dependencies.
package frmavg_pkg;

  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned FPS_W       = 25;
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned FRAC_BITS   = 8;
  localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_e;

endpackage

// File: src/frame_rate_moving_average_unit.sv
`timescale 1ns / 1ps
// Frame rate moving average unit.
// Input beat: tick_delta_i, one frame's elapsed time in ms (valid/ready).
// Output beat: fps_q8_o = floor(1000 * WINDOW * 256 / sum) in Q17.8, plus
// sum_zero_o when the window sum is zero (fps_q8_o is then all ones).
// A ring memory of WINDOW deltas keeps the last window; each beat reads the
// oldest entry, updates the running sum and writes the new delta back.
// The rate then comes from a restoring divider, one quotient bit per cycle.
// Path: the ring registers the oldest entry and the new delta, then the
// new sum; the divider loads that sum and builds a DVD_W-bit quotient, where
// DVD_W is the bit width of 256000 * WINDOW (25 at WINDOW = 100); on a zero
// window sum the division is skipped. One item is worked on at a time; the
// next beat is taken once the previous result is in the output register.
// A finished result sits in the output register; the next input beat is
// accepted while it waits. If the receiver still stalls when the following
// result is ready, the block holds that result and takes no new input.
// Reset clears the wrap flag (unwritten entries read as zero), the sum and the
// index; no clearing pass is needed, the block is ready right after reset.
module frame_rate_moving_average_unit #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [frmavg_pkg::DELTA_W-1:0]  tick_delta_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [frmavg_pkg::FPS_W-1:0]    fps_q8_o,
  output logic                            sum_zero_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW * 65535 + 1);

  frmavg_pkg::state_e state_q, state_d;

  logic                           in_fire;
  logic                           ring_done;
  logic [SUM_W-1:0]               ring_sum;
  logic                           div_done;
  logic [frmavg_pkg::FPS_W-1:0]   div_fps;
  logic                           div_zero;
  logic                           out_free;
  logic                           load_out;
  logic                           out_valid_q;
  logic [frmavg_pkg::FPS_W-1:0]   fps_q;
  logic                           zero_q;

  assign in_ready_o = (state_q == frmavg_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = out_free && ((state_q == frmavg_pkg::S_BUSY && div_done) ||
                                   state_q == frmavg_pkg::S_HOLD);

  frmavg_ring #(.WINDOW(WINDOW)) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .delta_i (tick_delta_i),
    .done_o  (ring_done),
    .sum_o   (ring_sum)
  );

  frmavg_div #(.WINDOW(WINDOW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ring_done),
    .sum_i   (ring_sum),
    .done_o  (div_done),
    .fps_o   (div_fps),
    .zero_o  (div_zero)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      frmavg_pkg::S_IDLE: begin
        if (in_fire) state_d = frmavg_pkg::S_BUSY;
      end
      frmavg_pkg::S_BUSY: begin
        if (div_done) state_d = out_free ? frmavg_pkg::S_IDLE : frmavg_pkg::S_HOLD;
      end
      frmavg_pkg::S_HOLD: begin
        if (out_free) state_d = frmavg_pkg::S_IDLE;
      end
      default: state_d = frmavg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frmavg_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      fps_q       <= '0;
      zero_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
        fps_q       <= div_fps;
        zero_q      <= div_zero;
      end else if (out_ready_i) begin
        // drop the beat once taken
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign fps_q8_o    = fps_q;
  assign sum_zero_o  = zero_q;

  a_ring_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_done |-> state_q == frmavg_pkg::S_BUSY)
    else $error("ring update finished outside a busy item");

  a_div_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == frmavg_pkg::S_BUSY)
    else $error("divider finished outside a busy item");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sum_zero_o |-> fps_q8_o == frmavg_pkg::FPS_MAX)
    else $error("zero sum without saturated rate");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

endmodule

// File: src/frmavg_ring.sv
`timescale 1ns / 1ps
// Delta ring memory with running window sum and write index.
// Read-modify-write per beat: read the oldest entry, then write the delta and update the sum; depends on frmavg_pkg.
module frmavg_ring #(
  parameter int unsigned WINDOW = 100,
  localparam int unsigned IDX_W = $clog2(WINDOW),
  localparam int unsigned SUM_W = $clog2(WINDOW * 65535 + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [frmavg_pkg::DELTA_W-1:0]    delta_i,
  output logic                              done_o,
  output logic [SUM_W-1:0]                  sum_o
);

  logic [frmavg_pkg::DELTA_W-1:0] mem [WINDOW];
  logic [frmavg_pkg::DELTA_W-1:0] rd_data_q;
  logic [frmavg_pkg::DELTA_W-1:0] delta_q;
  logic [frmavg_pkg::DELTA_W-1:0] old_delta;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [SUM_W-1:0]               sum_q, sum_d;
  logic                           upd_q;
  logic                           done_q;
  logic                           wrapped_q;

  // Entries not yet written since reset read as zero.
  assign old_delta = wrapped_q ? rd_data_q : '0;
  assign sum_d     = sum_q - SUM_W'(old_delta) + SUM_W'(delta_q);
  assign idx_d     = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rd_data_q <= mem[idx_q];
      delta_q   <= delta_i;
    end
    if (upd_q) begin
      mem[idx_q] <= delta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      sum_q     <= '0;
      upd_q     <= 1'b0;
      done_q    <= 1'b0;
      wrapped_q <= 1'b0;
    end else begin
      upd_q  <= start_i;
      done_q <= upd_q;
      if (upd_q) begin
        sum_q <= sum_d;
        idx_q <= idx_d;
        if (idx_q == IDX_W'(WINDOW - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

// File: src/frmavg_div.sv
`timescale 1ns / 1ps
// Restoring divider: 1000 * WINDOW * 256 over the window sum, one bit per cycle.
// Saturates on a zero sum or a too-wide quotient; depends on frmavg_pkg.
module frmavg_div #(
  parameter int unsigned WINDOW = 100,
  localparam int unsigned SUM_W = $clog2(WINDOW * 65535 + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [SUM_W-1:0]                sum_i,
  output logic                            done_o,
  output logic [frmavg_pkg::FPS_W-1:0]    fps_o,
  output logic                            zero_o
);

  localparam int unsigned DIVIDEND =
    frmavg_pkg::MS_PER_SEC * WINDOW * (2 ** frmavg_pkg::FRAC_BITS);
  localparam int unsigned DVD_W = $clog2(DIVIDEND + 1);
  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam int unsigned EXT_W = (DVD_W > frmavg_pkg::FPS_W) ? DVD_W : frmavg_pkg::FPS_W;

  logic [SUM_W-1:0] dvsr_q;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W:0]   trial;
  logic             qbit;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             zero_q;
  logic [EXT_W-1:0] quo_ext;
  logic             over;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvsr_q});
  assign rem_d = qbit ? SUM_W'(trial - {1'b0, dvsr_q}) : trial[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvsr_q <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvsr_q <= sum_i;
        rem_q  <= '0;
        dvd_q  <= DVD_W'(DIVIDEND);
        quo_q  <= '0;
        cnt_q  <= '0;
        if (sum_i == '0) begin
          // skip the division, result saturates
          zero_q <= 1'b1;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          zero_q <= 1'b0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DVD_W-2:0], qbit};
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_ext = EXT_W'(quo_q);
  assign over    = (quo_ext > EXT_W'(frmavg_pkg::FPS_MAX));

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign fps_o  = (zero_q || over) ? frmavg_pkg::FPS_MAX : quo_ext[frmavg_pkg::FPS_W-1:0];

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for frame_rate_moving_average_unit: a directed table, then random frame deltas
// in four phases of idles and stalls, each rate beat checked against a boxcar window tracked in the bench.
// Depends on frmavg_pkg and the unit itself; self-contained otherwise.
module tb_top;

  localparam int unsigned DELTA_W        = frmavg_pkg::DELTA_W;
  localparam int unsigned FPS_W          = frmavg_pkg::FPS_W;
  localparam logic [FPS_W-1:0] FPS_MAX   = frmavg_pkg::FPS_MAX;
  localparam int unsigned WINDOW         = 100;
  localparam longint unsigned RATE_NUM   =
    64'(frmavg_pkg::MS_PER_SEC) * WINDOW * (64'd1 << frmavg_pkg::FRAC_BITS);
  localparam int unsigned N_TABLE        = 18;
  localparam int unsigned RAND_PER_PHASE = 290;
  localparam int unsigned ZERO_RUN       = 104;
  localparam int unsigned BURST_ITEMS    = 24;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [FPS_W-1:0] fps;
    logic             zero_flag;
  } rate_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic               has_exp;
    logic [FPS_W-1:0]   fps;
    logic               zero_flag;
  } frame_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid     = 1'b0;
  logic [DELTA_W-1:0] tick_delta   = '0;
  logic               out_ready    = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [FPS_W-1:0]   fps_q8;
  logic               sum_zero;

  // Window state of the bench's own predictor.
  logic [DELTA_W-1:0] win_ring [WINDOW] = '{default: '0};
  longint unsigned    win_sum = 0;
  int unsigned        win_idx = 0;

  rate_t pending_rates [$];

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  bit          hold_req     = 1'b0;
  int unsigned frames_sent  = 0;
  int unsigned rates_seen   = 0;
  int unsigned zero_rates   = 0;
  int unsigned mismatches   = 0;
  int unsigned longest_wait = 0;

  // Directed rows; a typed-in rate is used where it is obvious, else the predictor decides.
  frame_row_t frame_table [N_TABLE] = '{
    '{16'h0000, 1'b1, FPS_MAX,       1'b1},  // empty window after reset
    '{16'h0000, 1'b1, FPS_MAX,       1'b1},
    '{16'h0001, 1'b1, 25'd25600000,  1'b0},  // sum of one: fastest rate
    '{16'h0000, 1'b1, 25'd25600000,  1'b0},
    '{16'hFFFF, 1'b0, '0,            1'b0},
    '{16'hFFFF, 1'b0, '0,            1'b0},
    '{16'hFFFE, 1'b0, '0,            1'b0},
    '{16'h0002, 1'b0, '0,            1'b0},
    '{16'h0010, 1'b0, '0,            1'b0},
    '{16'h0011, 1'b0, '0,            1'b0},
    '{16'h0021, 1'b0, '0,            1'b0},
    '{16'h8000, 1'b0, '0,            1'b0},
    '{16'h7FFF, 1'b0, '0,            1'b0},
    '{16'h5555, 1'b0, '0,            1'b0},
    '{16'hAAAA, 1'b0, '0,            1'b0},
    '{16'h00FF, 1'b0, '0,            1'b0},
    '{16'hFF00, 1'b0, '0,            1'b0},
    '{16'h0000, 1'b0, '0,            1'b0}
  };

  frame_rate_moving_average_unit #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .tick_delta_i(tick_delta),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .fps_q8_o    (fps_q8),
    .sum_zero_o  (sum_zero)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Slide the window by one delta and return the rate it yields.
  function automatic rate_t predict_rate(input logic [DELTA_W-1:0] d);
    rate_t           r;
    longint unsigned q;
    win_sum = win_sum - win_ring[win_idx] + d;
    win_ring[win_idx] = d;
    win_idx = (win_idx == WINDOW - 1) ? 0 : win_idx + 1;
    if (win_sum == 0) begin
      r.fps       = FPS_MAX;
      r.zero_flag = 1'b1;
    end else begin
      q = RATE_NUM / win_sum;
      if (q > FPS_MAX) q = FPS_MAX;
      r.fps       = q[FPS_W-1:0];
      r.zero_flag = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(9))
      0, 1, 2, 3: return DELTA_W'($urandom_range(40, 8));  // ordinary frame times
      4:          return DELTA_W'($urandom_range(255));
      5:          return '0;
      6:          return '1;
      default:    return DELTA_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Offer one beat, wait for its accept, then queue the rate it must produce.
  task automatic send_frame(input logic [DELTA_W-1:0] d, input logic use_row,
                            input rate_t row_rate);
    rate_t r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    tick_delta <= d;
    do @(posedge clk_i); while (!in_ready);
    r = predict_rate(d);
    pending_rates.push_back(use_row ? row_rate : r);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    send_frame(pick_delta(), 1'b0, '0);
  endtask

  // Stop offering and let every queued rate come out.
  task automatic wait_for_rates();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input rate_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected fps_q8=%0d sum_zero=%0b, got fps_q8=%0d sum_zero=%0b",
               $realtime, what, want.fps, want.zero_flag, fps_q8, sum_zero);
  endtask

  // Receiver: check each rate beat and drive ready for the next cycle.
  initial begin
    rate_t       want;
    int unsigned hold_left;
    int unsigned wait_len;
    hold_left = 0;
    wait_len  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        rates_seen++;
        if (sum_zero) zero_rates++;
        if (pending_rates.size() == 0) begin
          note_mismatch("rate beat with nothing pending", '0);
        end else begin
          want = pending_rates.pop_front();
          if (fps_q8 !== want.fps || sum_zero !== want.zero_flag)
            note_mismatch("rate mismatch", want);
        end
      end
      wait_len = (out_valid && !out_ready) ? wait_len + 1 : 0;
      if (wait_len > longest_wait) longest_wait = wait_len;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, quiet);
        $display("** frame_rate_moving_average_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned idle_by_phase  [4];
    int unsigned stall_by_phase [4];
    idle_by_phase  = '{0, 75, 0, 18};
    stall_by_phase = '{0, 0, 75, 18};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (frame_table[i])
      send_frame(frame_table[i].delta, frame_table[i].has_exp,
                 '{fps: frame_table[i].fps, zero_flag: frame_table[i].zero_flag});
    wait_for_rates();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 0) begin
        // Hold the receiver off while beats keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (BURST_ITEMS) send_random_frame();
        wait_for_rates();
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        // Flush the whole window with zeros so the sum drops back to zero.
        if (i == 120 && p % 2 == 1)
          repeat (ZERO_RUN) send_frame('0, 1'b0, '0);
        send_random_frame();
      end
      wait_for_rates();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d frame deltas, checked %0d rate beats (%0d with a zero window sum).",
             frames_sent, rates_seen, zero_rates);
    $display("Longest output stall: %0d cycles; mismatches: %0d.", longest_wait, mismatches);
    if (mismatches == 0 && pending_rates.size() == 0) begin
      $display("** frame_rate_moving_average_unit: PASSED **");
    end else begin
      $display("** frame_rate_moving_average_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/frmavg_pkg.sv
src/frmavg_ring.sv
src/frmavg_div.sv
src/frame_rate_moving_average_unit.sv
test/tb_top.sv
